[hdl/srcd_pkg.sv]
// shared types, constants and helpers for the sensor record cbor decoder
`timescale 1ns / 1ps
`default_nettype none
package srcd_pkg;

   localparam int unsigned SOIL_SLOTS_DEFAULT = 8;
   localparam int unsigned NUM_FIELDS = 11;
   localparam logic [4:0] AI_MASK = 5'h1F;
   localparam logic [4:0] AI_ONE_BYTE = 5'd24;
   localparam logic [4:0] AI_TWO_BYTE = 5'd25;
   localparam logic [4:0] AI_FOUR_BYTE = 5'd26;
   localparam logic [3:0] KEY_VERSION = 4'd13;
   localparam logic [3:0] KEY_SOIL = 4'd12;
   localparam logic [3:0] KEY_SOIL_COUNT = 4'd11;

   localparam logic [2:0] MT_UINT = 3'd0;
   localparam logic [2:0] MT_NINT = 3'd1;
   localparam logic [2:0] MT_ARRAY = 3'd4;
   localparam logic [2:0] MT_MAP = 3'd5;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EARLY_END = 2'd1;
   localparam logic [1:0] ST_BAD_HEADER = 2'd2;

   typedef enum logic [2:0] {
      PH_MAP = 3'd0,
      PH_KEY = 3'd1,
      PH_VAL = 3'd2,
      PH_ELEM = 3'd3,
      PH_ARG = 3'd4,
      PH_DRAIN = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [4:0] field_id;
      logic [31:0] field_value;
      logic [1:0] status;
      logic last_result;
   } rsp_type;

   // request from the parser to the result sequencer
   typedef struct packed {
      logic emit_record;
      logic emit_error;
      logic [1:0] err_status;
   } emit_type;

   // field truncation mask by field index
   function automatic logic [31:0] field_mask(input logic [3:0] idx);
      logic [31:0] m;
      m = 32'h0000_FFFF;
      if (idx == 4'd0) m = 32'hFFFF_FFFF;
      else if (idx >= 4'd8) m = 32'h0000_00FF;
      return m;
   endfunction

endpackage
`default_nettype wire

[hdl/srcd_parser.sv]
// byte parser: cbor header decode, argument assembly and record storage
`timescale 1ns / 1ps
`default_nettype none
module srcd_parser #(
   parameter int unsigned SOIL_SLOTS = srcd_pkg::SOIL_SLOTS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic take,
   input wire srcd_pkg::req_type req,
   input wire logic snap_busy,
   output srcd_pkg::emit_type emit,
   output logic [srcd_pkg::NUM_FIELDS-1:0][31:0] rec_out,
   output logic [SOIL_SLOTS-1:0][15:0] soil_out,
   output logic [4:0] lnz_out,
   output logic [1:0] seen_out
);
   localparam int unsigned SW = $clog2(SOIL_SLOTS + 1);

   logic [srcd_pkg::NUM_FIELDS-1:0][31:0] rec_ff, rec_in;
   logic [SOIL_SLOTS-1:0][15:0] soil_ff, soil_in;
   logic [4:0] lnz_ff, lnz_in;
   logic [1:0] seen_ff, seen_in;
   logic [31:0] pairs_ff, pairs_in;
   logic [32:0] items_ff, items_in;
   logic [31:0] acc_ff, acc_in;
   logic [2:0] abl_ff, abl_in;
   srcd_pkg::phase_type phase_ff, phase_in;
   logic [3:0] cls_ff, cls_in;
   srcd_pkg::phase_type ctx_ff, ctx_in;
   logic neg_ff, neg_in;
   logic [2:0] hmaj_ff, hmaj_in;
   logic [SW-1:0] sidx_ff, sidx_in;
   srcd_pkg::emit_type emit_in;

   logic [2:0] major;
   logic [4:0] ai;
   logic [31:0] acc_shift;

   assign major = req.data_byte[7:5];
   assign ai = req.data_byte[4:0] & srcd_pkg::AI_MASK;
   assign acc_shift = {acc_ff[23:0], req.data_byte};

   // next state for one accepted byte
   always_comb begin
      logic allowed, fin;
      srcd_pkg::phase_type fctx;
      logic [31:0] arg, v;
      logic pdone;
      logic [31:0] pairs_dec;
      logic [32:0] items_dec;
      rec_in = rec_ff;
      soil_in = soil_ff;
      lnz_in = lnz_ff;
      seen_in = seen_ff;
      pairs_in = pairs_ff;
      items_in = items_ff;
      acc_in = acc_ff;
      abl_in = abl_ff;
      phase_in = phase_ff;
      cls_in = cls_ff;
      ctx_in = ctx_ff;
      neg_in = neg_ff;
      hmaj_in = hmaj_ff;
      sidx_in = sidx_ff;
      emit_in = '0;
      allowed = 1'b0;
      fin = 1'b0;
      fctx = phase_ff;
      arg = '0;
      pdone = 1'b0;
      v = '0;
      pairs_dec = pairs_ff - 32'd1;
      items_dec = items_ff - 33'd1;
      if (take) begin
         if (phase_ff == srcd_pkg::PH_ARG) begin
            acc_in = acc_shift;
            if (abl_ff > 3'd0) abl_in = abl_ff - 3'd1;
            if (abl_ff <= 3'd1) begin
               fin = 1'b1;
               fctx = ctx_ff;
               arg = acc_shift;
            end
         end else if (phase_ff != srcd_pkg::PH_DRAIN) begin
            // header byte: check major type against position
            if (phase_ff == srcd_pkg::PH_MAP) allowed = (major == srcd_pkg::MT_MAP);
            else if (phase_ff == srcd_pkg::PH_VAL && cls_ff == srcd_pkg::KEY_SOIL)
               allowed = (major == srcd_pkg::MT_ARRAY);
            else if (phase_ff == srcd_pkg::PH_VAL && cls_ff == 4'd0)
               allowed = (major <= srcd_pkg::MT_NINT) || (major == srcd_pkg::MT_ARRAY)
                  || (major == srcd_pkg::MT_MAP);
            else allowed = (major <= srcd_pkg::MT_NINT);
            if (!allowed || ai > srcd_pkg::AI_FOUR_BYTE) begin
               emit_in.emit_error = 1'b1;
               emit_in.err_status = srcd_pkg::ST_BAD_HEADER;
               phase_in = srcd_pkg::PH_DRAIN;
            end else begin
               neg_in = (major == srcd_pkg::MT_NINT);
               hmaj_in = major;
               if (ai < srcd_pkg::AI_ONE_BYTE) begin
                  fin = 1'b1;
                  arg = {27'd0, ai};
               end else begin
                  abl_in = (ai == srcd_pkg::AI_ONE_BYTE) ? 3'd1 :
                     ((ai == srcd_pkg::AI_TWO_BYTE) ? 3'd2 : 3'd4);
                  acc_in = '0;
                  ctx_in = phase_ff;
                  phase_in = srcd_pkg::PH_ARG;
               end
            end
         end
         // completed argument
         if (fin) begin
            v = neg_in ? ~arg : arg;
            case (fctx)
               srcd_pkg::PH_MAP: begin
                  pairs_in = arg;
                  if (arg == 32'd0) begin
                     emit_in.emit_record = 1'b1;
                     phase_in = srcd_pkg::PH_DRAIN;
                  end else phase_in = srcd_pkg::PH_KEY;
               end
               srcd_pkg::PH_KEY: begin
                  cls_in = (!neg_in && arg >= 32'd1 && arg <= 32'd13) ? arg[3:0] : 4'd0;
                  phase_in = srcd_pkg::PH_VAL;
               end
               srcd_pkg::PH_VAL: begin
                  if (cls_ff >= 4'd1 && cls_ff <= srcd_pkg::KEY_SOIL_COUNT) begin
                     rec_in[cls_ff - 4'd1] = v & srcd_pkg::field_mask(cls_ff - 4'd1);
                     if (cls_ff == srcd_pkg::KEY_SOIL_COUNT) seen_in[1] = 1'b1;
                     pdone = 1'b1;
                  end else if (cls_ff == srcd_pkg::KEY_VERSION) begin
                     pdone = 1'b1;
                  end else begin
                     if (cls_ff == srcd_pkg::KEY_SOIL) begin
                        soil_in = '0;
                        sidx_in = '0;
                        seen_in[0] = 1'b1;
                        items_in = {1'b0, arg};
                     end else if (hmaj_in == srcd_pkg::MT_ARRAY) items_in = {1'b0, arg};
                     else if (hmaj_in == srcd_pkg::MT_MAP) items_in = {arg, 1'b0};
                     else items_in = '0;
                     if (items_in == 33'd0) pdone = 1'b1;
                     else phase_in = srcd_pkg::PH_ELEM;
                  end
               end
               default: begin
                  if (cls_ff == srcd_pkg::KEY_SOIL && sidx_ff < SW'(SOIL_SLOTS)) begin
                     soil_in[sidx_ff[$clog2(SOIL_SLOTS > 1 ? SOIL_SLOTS : 2)-1:0]]
                        = v[15:0];
                     if (v[15:0] != 16'd0) lnz_in = 5'(sidx_ff) + 5'd1;
                  end
                  if (sidx_ff < SW'(SOIL_SLOTS)) sidx_in = sidx_ff + SW'(1);
                  items_in = items_dec;
                  if (items_dec == 33'd0) pdone = 1'b1;
                  else phase_in = srcd_pkg::PH_ELEM;
               end
            endcase
            if (pdone) begin
               pairs_in = pairs_dec;
               if (pairs_dec == 32'd0) begin
                  emit_in.emit_record = 1'b1;
                  phase_in = srcd_pkg::PH_DRAIN;
               end else phase_in = srcd_pkg::PH_KEY;
            end
         end
         // end flag: early end error and message clear
         if (req.end_of_buffer) begin
            if (phase_in != srcd_pkg::PH_DRAIN) begin
               emit_in = '0;
               emit_in.emit_error = 1'b1;
               emit_in.err_status = srcd_pkg::ST_EARLY_END;
            end
         end
      end
   end

   // parser state; the end flag clears after the snapshot is taken
   always_ff @(posedge clock) begin
      if (reset || (take && req.end_of_buffer)) begin
         rec_ff <= '0;
         soil_ff <= '0;
         lnz_ff <= '0;
         seen_ff <= '0;
         pairs_ff <= '0;
         items_ff <= '0;
         acc_ff <= '0;
         abl_ff <= '0;
         phase_ff <= srcd_pkg::PH_MAP;
         cls_ff <= '0;
         ctx_ff <= srcd_pkg::PH_MAP;
         neg_ff <= 1'b0;
         hmaj_ff <= '0;
         sidx_ff <= '0;
      end else begin
         rec_ff <= rec_in;
         soil_ff <= soil_in;
         lnz_ff <= lnz_in;
         seen_ff <= seen_in;
         pairs_ff <= pairs_in;
         items_ff <= items_in;
         acc_ff <= acc_in;
         abl_ff <= abl_in;
         phase_ff <= phase_in;
         cls_ff <= cls_in;
         ctx_ff <= ctx_in;
         neg_ff <= neg_in;
         hmaj_ff <= hmaj_in;
         sidx_ff <= sidx_in;
      end
   end

   // emit request and record snapshot are registered together
   logic [srcd_pkg::NUM_FIELDS-1:0][31:0] snap_rec_ff;
   logic [SOIL_SLOTS-1:0][15:0] snap_soil_ff;
   logic [4:0] snap_lnz_ff;
   logic [1:0] snap_seen_ff;
   srcd_pkg::emit_type emit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= '0;
      end else begin
         emit_ff <= emit_in;
      end
      if (emit_in.emit_record && !snap_busy) begin
         snap_rec_ff <= rec_in;
         snap_soil_ff <= soil_in;
         snap_lnz_ff <= lnz_in;
         snap_seen_ff <= seen_in;
      end
   end

   assign emit = emit_ff;
   assign rec_out = snap_rec_ff;
   assign soil_out = snap_soil_ff;
   assign lnz_out = snap_lnz_ff;
   assign seen_out = snap_seen_ff;
endmodule
`default_nettype wire

[hdl/srcd_sequencer.sv]
// result sequencer: walks the record snapshot out as field results
`timescale 1ns / 1ps
`default_nettype none
module srcd_sequencer #(
   parameter int unsigned SOIL_SLOTS = srcd_pkg::SOIL_SLOTS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire srcd_pkg::emit_type emit,
   input wire logic [srcd_pkg::NUM_FIELDS-1:0][31:0] rec,
   input wire logic [SOIL_SLOTS-1:0][15:0] soil,
   input wire logic [4:0] lnz,
   input wire logic [1:0] seen,
   output logic busy,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output srcd_pkg::rsp_type rsp_data
);
   localparam int unsigned TOTAL = srcd_pkg::NUM_FIELDS + SOIL_SLOTS;
   localparam int unsigned SIW = $clog2(SOIL_SLOTS > 1 ? SOIL_SLOTS : 2);

   logic run_ff, run_in;
   logic [4:0] idx_ff, idx_in;
   logic valid_ff, valid_in;
   srcd_pkg::rsp_type data_ff, data_in;
   logic advance;

   assign advance = !valid_ff || rsp_ready;

   // next result: an error is one transfer, a record is TOTAL transfers
   always_comb begin
      logic [31:0] val;
      run_in = run_ff;
      idx_in = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      data_in = data_ff;
      val = '0;
      if (advance) begin
         if (emit.emit_error) begin
            valid_in = 1'b1;
            data_in = '{field_id: 5'd0, field_value: 32'd0,
               status: emit.err_status, last_result: 1'b1};
         end else if (emit.emit_record || run_ff) begin
            if (idx_ff < 5'(srcd_pkg::NUM_FIELDS)) begin
               val = rec[idx_ff[3:0]];
               if (idx_ff == 5'(srcd_pkg::NUM_FIELDS - 1) && seen[0] && !seen[1])
                  val = {27'd0, lnz};
            end else begin
               val = {16'd0, soil[SIW'(idx_ff - 5'(srcd_pkg::NUM_FIELDS))]};
            end
            valid_in = 1'b1;
            data_in = '{field_id: idx_ff, field_value: val, status: srcd_pkg::ST_OK,
               last_result: (idx_ff == 5'(TOTAL - 1))};
            if (idx_ff == 5'(TOTAL - 1)) begin
               run_in = 1'b0;
               idx_in = '0;
            end else begin
               run_in = 1'b1;
               idx_in = idx_ff + 5'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         idx_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   // input is held during a run, a pending emit or a stalled result
   assign busy = run_ff || emit.emit_record || emit.emit_error || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;
endmodule
`default_nettype wire

[hdl/sensor_record_cbor_decoder.sv]
// Sensor record CBOR decoder, top level.
// req channel: one CBOR byte per transfer with an end_of_buffer flag on the
// last byte of each message. rsp channel: field results (field_id, value,
// status, last_result). A message yields either 11+SOIL_SLOTS field results
// once its map completes, or one error result (bad header or early end).
// Throughput: one byte per cycle while parsing, when req_ready is not held
// low; the parser is a single registered stage, so a byte is decoded in the
// cycle it is taken. A result transfer is offered from the result register,
// which loads from the emit register set by the byte that completes the map
// or raises the error. A pending emit, a result run of 11+SOIL_SLOTS
// transfers and a stalled result hold req_ready low; a record holds it for
// the emit register, then for one result per cycle from the snapshot while
// the receiver is ready. An error holds input while its emit is pending.
// When the receiver stalls, the result register holds and input waits.
// Reset clears parser, record and emit state and the result valid flag, but
// not the snapshot; the end flag clears parser state once its byte is taken.
`timescale 1ns / 1ps
`default_nettype none
module sensor_record_cbor_decoder #(
   parameter int unsigned SOIL_SLOTS = srcd_pkg::SOIL_SLOTS_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire srcd_pkg::req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output srcd_pkg::rsp_type rsp_data
);
   logic take, busy;
   srcd_pkg::emit_type emit;
   logic [srcd_pkg::NUM_FIELDS-1:0][31:0] rec;
   logic [SOIL_SLOTS-1:0][15:0] soil;
   logic [4:0] lnz;
   logic [1:0] seen;

   assign req_ready = !busy;
   assign take = req_valid && req_ready;

   srcd_parser #(.SOIL_SLOTS(SOIL_SLOTS)) u_parser (
      .clock(clock), .reset(reset), .take(take), .req(req_data), .snap_busy(1'b0),
      .emit(emit), .rec_out(rec), .soil_out(soil), .lnz_out(lnz), .seen_out(seen)
   );

   srcd_sequencer #(.SOIL_SLOTS(SOIL_SLOTS)) u_seq (
      .clock(clock), .reset(reset), .emit(emit), .rec(rec), .soil(soil), .lnz(lnz),
      .seen(seen), .busy(busy), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

[hdl/srcd_checker.sv]
// port-level checker for the sensor record cbor decoder
`timescale 1ns / 1ps
`default_nettype none
module srcd_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire srcd_pkg::rsp_type rsp_data
);
   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // error results carry zero value and the last flag
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != srcd_pkg::ST_OK |->
      rsp_data.last_result && rsp_data.field_value == 32'd0 && rsp_data.field_id == 5'd0)
      else $error("malformed error result");

   // no input is taken while results are stalled
   a_no_take_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken during output stall");

   // field ids step by one within a run
   a_id_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_result ##1 rsp_valid |->
      rsp_data.field_id == $past(rsp_data.field_id) + 5'd1)
      else $error("field id out of order");
endmodule

bind sensor_record_cbor_decoder srcd_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
`default_nettype wire
